### hw/rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on the rising edge, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define STRQ_ASSERT_SAME(lbl, clk_sig, rst_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define STRQ_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/strq_pkg.sv
package strq_pkg;

    localparam int unsigned LEAVES_DEFAULT = 1024;

    localparam int unsigned DATA_W     = 64;
    localparam int unsigned CMD_W      = 1;
    localparam int unsigned LEAF_IDX_W = 10;
    localparam int unsigned RANGE_W    = 11;
    localparam int unsigned MODE_W     = 2;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_MIN = 2'd0,
        MODE_MAX = 2'd1,
        MODE_SUM = 2'd2
    } mode_t;

    localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

    localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 1'b1;

    localparam data_t ID_MIN = 64'sd10000000000000000;
    localparam data_t ID_MAX = -64'sd10000000000000000;
    localparam data_t ID_SUM = 64'sd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_LEAF,
        ST_UPD_UP,
        ST_Q_ISSUE,
        ST_Q_STEP,
        ST_Q_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_start;
        logic clr_step;
        logic upd_leaf;
        logic upd_up;
        logic q_issue;
        logic q_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_query;
        logic upd_ok;
        logic cfg_ok;
        logic clr_last;
        logic upd_root;
        logic q_live;
    } dp_status_t;

    function automatic data_t identity_of(mode_t mode);
        data_t res;
        case (mode)
            MODE_MIN: res = ID_MIN;
            MODE_MAX: res = ID_MAX;
            default:  res = ID_SUM;
        endcase
        return res;
    endfunction

    function automatic data_t combine(mode_t mode, data_t a, data_t b);
        data_t res;
        case (mode)
            MODE_MIN: res = (b < a) ? b : a;
            MODE_MAX: res = (a < b) ? b : a;
            default:  res = a + b;
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/strq_req_if.sv
interface strq_req_if;
    logic                                valid;
    logic                                ready;
    logic [strq_pkg::CMD_W-1:0]          cmd;
    logic [strq_pkg::LEAF_IDX_W-1:0]     leaf_index;
    logic signed [strq_pkg::DATA_W-1:0]  leaf_value;
    logic [strq_pkg::RANGE_W-1:0]        range_lo;
    logic [strq_pkg::RANGE_W-1:0]        range_hi;

    modport source (
        output valid, cmd, leaf_index, leaf_value, range_lo, range_hi,
        input  ready
    );

    modport sink (
        input  valid, cmd, leaf_index, leaf_value, range_lo, range_hi,
        output ready
    );
endinterface

### hw/rtl/strq_rsp_if.sv
interface strq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [strq_pkg::DATA_W-1:0]  combined_value;

    modport source (
        output valid, combined_value,
        input  ready
    );

    modport sink (
        input  valid, combined_value,
        output ready
    );
endinterface

### hw/rtl/strq_datapath.sv
module strq_datapath #(
    parameter int unsigned LEAVES = strq_pkg::LEAVES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  strq_pkg::ctrl_cmd_t                 ctl,
    output strq_pkg::dp_status_t                status,
    input  logic                                cfg_wr_en,
    input  logic [strq_pkg::MODE_W-1:0]         cfg_wr_data,
    input  logic [strq_pkg::CMD_W-1:0]          req_cmd,
    input  logic [strq_pkg::LEAF_IDX_W-1:0]     leaf_index,
    input  logic signed [strq_pkg::DATA_W-1:0]  leaf_value,
    input  logic [strq_pkg::RANGE_W-1:0]        range_lo,
    input  logic [strq_pkg::RANGE_W-1:0]        range_hi,
    output logic signed [strq_pkg::DATA_W-1:0]  rsp_value
);

    localparam int unsigned LEAF_AW = $clog2(LEAVES);
    localparam int unsigned NODE_AW = LEAF_AW + 1;
    localparam int unsigned IW      = NODE_AW + 1;
    localparam int unsigned POW     = 32'd1 << LEAF_AW;
    localparam int unsigned DEPTH   = 32'd1 << NODE_AW;

    strq_pkg::data_t mem [DEPTH];

    strq_pkg::mode_t     mode_reg;
    logic [NODE_AW-1:0]  clr_cnt_reg;
    logic [NODE_AW-1:0]  node_reg,  node_next;
    strq_pkg::data_t     carry_reg, carry_next;
    logic [IW-1:0]       l_reg, l_next;
    logic [IW-1:0]       r_reg, r_next;
    strq_pkg::data_t     lacc_reg, lacc_next;
    strq_pkg::data_t     racc_reg, racc_next;
    strq_pkg::data_t     rd_a_reg, rd_b_reg;
    strq_pkg::data_t     rsp_reg;

    logic                we;
    logic [NODE_AW-1:0]  waddr;
    strq_pkg::data_t     wdata;
    logic [NODE_AW-1:0]  raddr_a, raddr_b;

    logic [NODE_AW-1:0]  parent;
    strq_pkg::data_t     up_value;
    logic [31:0]         hi_clamp;
    logic                q_empty;
    logic [IW-1:0]       l_step, r_step, l_inc, rb_src;
    strq_pkg::data_t     ident;

    assign ident    = strq_pkg::identity_of(mode_reg);
    assign parent   = node_reg >> 1;
    assign up_value = node_reg[0] ? strq_pkg::combine(mode_reg, rd_a_reg, carry_reg)
                                  : strq_pkg::combine(mode_reg, carry_reg, rd_a_reg);
    assign hi_clamp = (32'(range_hi) > LEAVES) ? LEAVES : 32'(range_hi);
    assign q_empty  = 32'(range_lo) >= hi_clamp;
    assign l_inc    = l_reg + IW'(l_reg[0]);
    assign l_step   = l_inc >> 1;
    assign r_step   = r_reg >> 1;

    assign status.is_query = (req_cmd == strq_pkg::CMD_QUERY);
    assign status.upd_ok   = 32'(leaf_index) < LEAVES;
    assign status.cfg_ok   = (cfg_wr_data != strq_pkg::MODE_INVALID);
    assign status.clr_last = &clr_cnt_reg;
    assign status.upd_root = (parent == NODE_AW'(1));
    assign status.q_live   = (l_reg < r_reg);

    assign rsp_value = rsp_reg;

    always_comb
    begin
        we      = 1'b0;
        waddr   = clr_cnt_reg;
        wdata   = ident;
        raddr_a = l_reg[NODE_AW-1:0];
        rb_src  = r_reg - IW'(1);
        if (ctl.clr_step)
        begin
            we = 1'b1;
        end
        else if (ctl.upd_leaf)
        begin
            we      = 1'b1;
            waddr   = node_reg;
            wdata   = carry_reg;
            raddr_a = node_reg ^ NODE_AW'(1);
        end
        else if (ctl.upd_up)
        begin
            we      = 1'b1;
            waddr   = parent;
            wdata   = up_value;
            raddr_a = parent ^ NODE_AW'(1);
        end
        else if (ctl.q_step)
        begin
            raddr_a = l_step[NODE_AW-1:0];
            rb_src  = r_step - IW'(1);
        end
        raddr_b = rb_src[NODE_AW-1:0];
    end

    always_comb
    begin
        node_next  = node_reg;
        carry_next = carry_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        lacc_next  = lacc_reg;
        racc_next  = racc_reg;
        if (ctl.load)
        begin
            node_next  = NODE_AW'(32'(POW) + 32'(leaf_index));
            carry_next = leaf_value;
            l_next     = q_empty ? '0 : IW'(32'(range_lo) + 32'(POW));
            r_next     = q_empty ? '0 : IW'(hi_clamp + 32'(POW));
            lacc_next  = ident;
            racc_next  = ident;
        end
        else if (ctl.upd_up)
        begin
            node_next  = parent;
            carry_next = up_value;
        end
        else if (ctl.q_step && status.q_live)
        begin
            if (l_reg[0])
            begin
                lacc_next = strq_pkg::combine(mode_reg, lacc_reg, rd_a_reg);
            end
            if (r_reg[0])
            begin
                racc_next = strq_pkg::combine(mode_reg, rd_b_reg, racc_reg);
            end
            l_next = l_step;
            r_next = r_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= strq_pkg::MODE_MAX;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en && status.cfg_ok)
            begin
                mode_reg <= strq_pkg::mode_t'(cfg_wr_data);
            end
            if (ctl.clr_start)
            begin
                clr_cnt_reg <= '0;
            end
            else if (ctl.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + NODE_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        carry_reg <= carry_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        lacc_reg  <= lacc_next;
        racc_reg  <= racc_next;
        if (ctl.out_load)
        begin
            rsp_reg <= strq_pkg::combine(mode_reg, lacc_reg, racc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

endmodule

### hw/rtl/strq_ctrl.sv
module strq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  strq_pkg::dp_status_t  status,
    output strq_pkg::ctrl_cmd_t   ctl
);

    strq_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             restart;
    logic             accept;
    logic             slot_free;

    assign restart   = cfg_wr_en && status.cfg_ok;
    assign req_ready = (state_reg == strq_pkg::ST_IDLE) && !cfg_wr_en;
    assign accept    = req_valid && req_ready;
    assign slot_free = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            strq_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = strq_pkg::ST_IDLE;
                end
            end
            strq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.is_query)
                    begin
                        state_next = strq_pkg::ST_Q_ISSUE;
                    end
                    else if (status.upd_ok)
                    begin
                        state_next = strq_pkg::ST_UPD_LEAF;
                    end
                end
            end
            strq_pkg::ST_UPD_LEAF:
            begin
                state_next = strq_pkg::ST_UPD_UP;
            end
            strq_pkg::ST_UPD_UP:
            begin
                if (status.upd_root)
                begin
                    state_next = strq_pkg::ST_IDLE;
                end
            end
            strq_pkg::ST_Q_ISSUE:
            begin
                state_next = strq_pkg::ST_Q_STEP;
            end
            strq_pkg::ST_Q_STEP:
            begin
                if (!status.q_live)
                begin
                    state_next = strq_pkg::ST_Q_DONE;
                end
            end
            strq_pkg::ST_Q_DONE:
            begin
                if (slot_free)
                begin
                    state_next = strq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = strq_pkg::ST_IDLE;
            end
        endcase
        if (restart)
        begin
            state_next = strq_pkg::ST_CLEAR;
        end
    end

    always_comb
    begin
        ctl            = '0;
        ctl.clr_start  = restart;
        ctl.load       = accept;
        out_valid_next = out_valid_reg && !rsp_ready;
        unique case (state_reg)
            strq_pkg::ST_CLEAR:
            begin
                ctl.clr_step = !restart;
            end
            strq_pkg::ST_UPD_LEAF:
            begin
                ctl.upd_leaf = 1'b1;
            end
            strq_pkg::ST_UPD_UP:
            begin
                ctl.upd_up = 1'b1;
            end
            strq_pkg::ST_Q_ISSUE:
            begin
                ctl.q_issue = 1'b1;
            end
            strq_pkg::ST_Q_STEP:
            begin
                ctl.q_step = 1'b1;
            end
            strq_pkg::ST_Q_DONE:
            begin
                ctl.out_load = slot_free;
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                ctl.q_issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= strq_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/segment_tree_range_query.sv
// Segment tree over LEAVES signed 64-bit leaves, combining by minimum, maximum or
// wrapping sum as the mode on cfg_wr_data selects (0, 1, 2; a write of 3 is
// dropped). The tree lives in one node memory of 2*P words, P being LEAVES
// rounded up to a power of two. After reset, and after every accepted mode
// write, a clearing pass writes the mode's identity to all 2*P words, one a
// cycle, with request.ready low. Items are taken one at a time. An update is
// captured, then writes the leaf, then takes one step per ancestor, each step
// reading the sibling and writing the parent. A query is captured, issues its
// reads, takes one step per tree level on the two read ports, and ends with
// the final combine into the output register. The next item is accepted while
// a query result waits in the output register; a query that reaches its final
// combine while an earlier result still waits holds there until that result
// is taken.
module segment_tree_range_query #(
    parameter int unsigned LEAVES = strq_pkg::LEAVES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [strq_pkg::MODE_W-1:0]  cfg_wr_data,
    strq_req_if.sink                     request,
    strq_rsp_if.source                   response
);

    strq_pkg::ctrl_cmd_t   ctl;
    strq_pkg::dp_status_t  status;

    strq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (response.valid),
        .rsp_ready (response.ready),
        .status    (status),
        .ctl       (ctl)
    );

    strq_datapath #(
        .LEAVES (LEAVES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_cmd     (request.cmd),
        .leaf_index  (request.leaf_index),
        .leaf_value  (request.leaf_value),
        .range_lo    (request.range_lo),
        .range_hi    (request.range_hi),
        .rsp_value   (response.combined_value)
    );

endmodule

### hw/rtl/strq_checker.sv
`include "assert_macros.svh"

module strq_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [strq_pkg::MODE_W-1:0]         cfg_wr_data,
    input  logic                                req_valid,
    input  logic                                req_ready,
    input  logic [strq_pkg::CMD_W-1:0]          req_cmd,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic signed [strq_pkg::DATA_W-1:0]  rsp_value
);

    logic [1:0] pend_reg, pend_next;
    logic       q_acc;
    logic       r_acc;

    assign q_acc = req_valid && req_ready && (req_cmd == strq_pkg::CMD_QUERY);
    assign r_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg + 2'(q_acc) - 2'(r_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `STRQ_ASSERT_SAME(a_rsp_has_query, clk, rst_n, rsp_valid, pend_reg != 2'd0, "result without query")
    `STRQ_ASSERT_SAME(a_pend_bound, clk, rst_n, 1'b1, pend_reg != 2'd3, "too many open queries")
    `STRQ_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_wr_en && (cfg_wr_data != strq_pkg::MODE_INVALID), !req_ready, "item taken during clear")
    `STRQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value), "result dropped")

endmodule

bind segment_tree_range_query strq_checker u_strq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .req_cmd     (request.cmd),
    .rsp_valid   (response.valid),
    .rsp_ready   (response.ready),
    .rsp_value   (response.combined_value)
);

### tb/sv/range_query_checker.sv
module range_query_checker
    import strq_pkg::*;
#(
    parameter int unsigned LEAVES = LEAVES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [MODE_W-1:0] cfg_wr_data,
    strq_req_if               request,
    strq_rsp_if               response,
    output int unsigned       mismatches,
    output int unsigned       results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SPAN = 1 << $clog2(LEAVES);

    mode_t active_mode;
    data_t node_val [1:2*SPAN-1];
    data_t answers_due [$];

    function automatic data_t mode_identity(mode_t m);
        case (m)
            MODE_MIN: return ID_MIN;
            MODE_MAX: return ID_MAX;
            default:  return ID_SUM;
        endcase
    endfunction

    function automatic data_t merge(data_t a, data_t b);
        case (active_mode)
            MODE_MIN: return (a < b) ? a : b;
            MODE_MAX: return (a < b) ? b : a;
            default:  return a + b;
        endcase
    endfunction

    function automatic void fill_tree();
        foreach (node_val[i])
        begin
            node_val[i] = mode_identity(active_mode);
        end
    endfunction

    function automatic void write_leaf(int unsigned idx, data_t v);
        int unsigned n;
        n = SPAN + idx;
        node_val[n] = v;
        while (n > 1)
        begin
            n = n >> 1;
            node_val[n] = merge(node_val[2*n], node_val[2*n+1]);
        end
    endfunction

    function automatic data_t span_result(int unsigned lo, int unsigned hi);
        data_t left_part;
        data_t right_part;
        int unsigned l;
        int unsigned r;
        left_part  = mode_identity(active_mode);
        right_part = left_part;
        if (hi > LEAVES)
        begin
            hi = LEAVES;
        end
        if (lo < hi)
        begin
            l = lo + SPAN;
            r = hi + SPAN;
            while (l < r)
            begin
                if ((l & 1) != 0)
                begin
                    left_part = merge(left_part, node_val[l]);
                    l++;
                end
                if ((r & 1) != 0)
                begin
                    r--;
                    right_part = merge(node_val[r], right_part);
                end
                l = l >> 1;
                r = r >> 1;
            end
        end
        return merge(left_part, right_part);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        data_t due;
        if (!rst_n)
        begin
            active_mode = MODE_MAX;
            fill_tree();
            answers_due.delete();
            mismatches = 0;
            results_pending <= 0;
        end
        else
        begin
            if (response.valid && response.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, response.combined_value);
                    mismatches++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (response.combined_value !== due)
                    begin
                        $display("%0t: combined_value mismatch, expected %0d, got %0d",
                                 $time, due, response.combined_value);
                        mismatches++;
                    end
                end
            end
            if (cfg_wr_en && cfg_wr_data != MODE_INVALID)
            begin
                active_mode = mode_t'(cfg_wr_data);
                fill_tree();
            end
            if (request.valid && request.ready)
            begin
                if (request.cmd == CMD_UPDATE)
                begin
                    if (request.leaf_index < LEAVES)
                    begin
                        write_leaf(request.leaf_index, request.leaf_value);
                    end
                end
                else
                begin
                    answers_due.push_back(span_result(request.range_lo, request.range_hi));
                end
            end
            results_pending <= answers_due.size();
        end
    end

endmodule

### tb/sv/testbench.sv
module testbench
    import strq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam data_t TOP_VAL    = {1'b0, {63{1'b1}}};
    localparam data_t BOTTOM_VAL = {1'b1, {63{1'b0}}};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en;
    logic [MODE_W-1:0] cfg_wr_data;

    bit          calm;
    int unsigned updates_sent;
    int unsigned queries_sent;
    int unsigned mode_writes;
    int unsigned mismatches;
    int unsigned results_pending;

    strq_req_if req_ch ();
    strq_rsp_if rsp_ch ();

    segment_tree_range_query dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (req_ch),
        .response    (rsp_ch)
    );

    range_query_checker span_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .request         (req_ch),
        .response        (rsp_ch),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    always #2 clk = ~clk;

    function automatic int unsigned pause_len();
        return calm ? 0 : $urandom_range(7, 0);
    endfunction

    task automatic send_item(logic [CMD_W-1:0] c, logic [LEAF_IDX_W-1:0] idx, data_t v,
                             logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
        int unsigned gap;
        gap = pause_len();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.cmd        <= c;
        req_ch.leaf_index <= idx;
        req_ch.leaf_value <= v;
        req_ch.range_lo   <= lo;
        req_ch.range_hi   <= hi;
        req_ch.valid      <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        if (c == CMD_UPDATE)
            updates_sent++;
        else
            queries_sent++;
    endtask

    task automatic update(logic [LEAF_IDX_W-1:0] idx, data_t v);
        send_item(CMD_UPDATE, idx, v, RANGE_W'($urandom), RANGE_W'($urandom));
    endtask

    task automatic query(logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
        send_item(CMD_QUERY, LEAF_IDX_W'($urandom), data_t'({$urandom, $urandom}), lo, hi);
    endtask

    // hold off until every result is back and the last update has settled
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_mode(logic [MODE_W-1:0] m);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        mode_writes++;
    endtask

    task automatic random_item(int unsigned base, int unsigned width);
        logic [LEAF_IDX_W-1:0] idx;
        data_t                 v;
        logic [RANGE_W-1:0]    lo;
        logic [RANGE_W-1:0]    hi;
        int unsigned           lo_i;
        if ($urandom_range(99, 0) < 50)
        begin
            if ($urandom_range(9, 0) == 0)
                idx = LEAF_IDX_W'($urandom);
            else
                idx = LEAF_IDX_W'(base + $urandom_range(width - 1, 0));
            case ($urandom_range(7, 0))
                0: v = TOP_VAL;
                1: v = BOTTOM_VAL;
                2: v = data_t'($urandom_range(2000, 0)) - 1000;
                3: v = (($urandom_range(1, 0) != 0) ? ID_MIN : ID_MAX)
                       + data_t'($urandom_range(2, 0)) - 1;
                default: v = data_t'({$urandom, $urandom});
            endcase
            update(idx, v);
        end
        else
        begin
            if ($urandom_range(9, 0) < 2)
            begin
                lo = RANGE_W'($urandom);
                hi = RANGE_W'($urandom);
            end
            else
            begin
                lo_i = base + $urandom_range(width, 0);
                lo   = RANGE_W'(lo_i);
                hi   = RANGE_W'($urandom_range(base + width, lo_i));
            end
            query(lo, hi);
        end
    endtask

    initial
    begin : drain
        int unsigned hold;
        rsp_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            hold = pause_len();
            if (hold != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    initial
    begin : stimulus
        mode_t       plan [7];
        int unsigned width;
        int unsigned base;
        plan = '{MODE_MIN, MODE_SUM, MODE_MAX, MODE_SUM, MODE_MIN, MODE_MAX, MODE_SUM};
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= MODE_MAX;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_UPDATE;
        req_ch.leaf_index <= '0;
        req_ch.leaf_value <= '0;
        req_ch.range_lo   <= '0;
        req_ch.range_hi   <= '0;
        calm = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        query(0, 1024);
        update(0, TOP_VAL);
        update(1023, BOTTOM_VAL);
        update(512, 0);
        update(1, ID_MAX);
        query(0, 1024);
        query(1023, 1024);
        query(1, 1023);
        query(9, 4);
        query(600, 600);
        query(1000, 2047);
        query(1024, 2047);
        query(2047, 0);
        write_mode(MODE_INVALID);
        query(0, 1024);
        write_mode(MODE_SUM);
        update(3, TOP_VAL);
        update(4, TOP_VAL);
        update(5, BOTTOM_VAL);
        query(3, 5);
        query(0, 1024);
        write_mode(MODE_MIN);
        query(0, 1024);
        update(700, BOTTOM_VAL);
        update(701, TOP_VAL);
        query(0, 1024);
        query(701, 1024);

        for (int ph = 0; ph < 7; ph++)
        begin
            write_mode(plan[ph]);
            calm = (ph % 3 == 2);
            for (int n = 0; n < 150; n++)
            begin
                if (n % 50 == 0)
                begin
                    case ($urandom_range(3, 0))
                        0:       width = 4;
                        1:       width = 32;
                        2:       width = 256;
                        default: width = 1024;
                    endcase
                    base = $urandom_range(1024 - width, 0);
                end
                random_item(base, width);
            end
        end
        calm = 1'b0;

        drain_results();
        $display("Covered %0d updates and %0d queries across %0d mode writes,",
                 updates_sent, queries_sent, mode_writes);
        $display("including ignored mode writes, clamped and empty spans, and stalls on both sides.");
        if (mismatches == 0 && results_pending == 0)
            $display("segment_tree_range_query test passed");
        else
            $display("segment_tree_range_query test failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("segment_tree_range_query test failed");
        $finish;
    end

endmodule

### segment_tree_range_query.f
+incdir+hw/rtl
hw/rtl/strq_pkg.sv
hw/rtl/strq_req_if.sv
hw/rtl/strq_rsp_if.sv
hw/rtl/strq_datapath.sv
hw/rtl/strq_ctrl.sv
hw/rtl/segment_tree_range_query.sv
hw/rtl/strq_checker.sv
tb/sv/range_query_checker.sv
tb/sv/testbench.sv
